FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files of the polar Gaussian unit.
// Expects signals clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define PGP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked property that must also hold while reset is asserted
`define PGP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pgp_pkg.sv
// Package for the polar Gaussian pair unit: constants, side-band structs and helpers.
// Used by every cell module and by the top level.
`default_nettype none

package pgp_pkg;

	localparam int UNIFORM_BITS_DEF  = 32;
	localparam int OUT_FRAC_BITS_DEF = 26;
	localparam int LOG_STEPS         = 56;
	localparam int ROOT_BITS         = 32;
	localparam int QUO_BITS          = 32;
	localparam int REM_W             = ROOT_BITS + 2;

	localparam logic [63:0] LN2X2_Q62    = 64'h58B9_0BFB_E8E7_BCD6;
	localparam logic [31:0] HALF_RANGE   = 32'h8000_0000;
	localparam logic [63:0] CIRCLE_LIMIT = 64'h4000_0000_0000_0000;

	// Side data carried along the log cells
	typedef struct packed {
		logic [5:0]  msb;
		logic [63:0] rad_norm;
		logic [31:0] vn1;
		logic [31:0] vn2;
		logic        neg1;
		logic        neg2;
	} log_side_t;

	// Side data carried along the root cells
	typedef struct packed {
		logic [31:0] vn1;
		logic [31:0] vn2;
		logic        neg1;
		logic        neg2;
	} root_side_t;

	// Index of the highest set bit
	function automatic logic [5:0] msb_index(input logic [63:0] r);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (r[i]) p = i[5:0];
		end
		return p;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/pgp_log_cell.sv
// One log2 fraction bit by squaring the Q1.63 mantissa; two register stages.
// Depends on pgp_pkg.
`default_nettype none

module pgp_log_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [63:0]           in_x,
	input  logic [pgp_pkg::LOG_STEPS-1:0] in_frac,
	input  pgp_pkg::log_side_t    in_side,
	output logic                  out_valid,
	output logic [63:0]           out_x,
	output logic [pgp_pkg::LOG_STEPS-1:0] out_frac,
	output pgp_pkg::log_side_t    out_side
);
	import pgp_pkg::*;

	logic                 v_s1, v_s2;
	logic [63:0]          p00_s1, p01_s1, p11_s1;
	logic [LOG_STEPS-1:0] frac_s1, frac_s2;
	log_side_t            side_s1, side_s2;
	logic [63:0]          x_s2;
	logic [127:0]         sq;
	logic [63:0]          hi;

	// Hold valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Recombine the square and keep its top 64 bits
	assign sq = {p11_s1, 64'd0} + {31'd0, p01_s1, 33'd0} + {64'd0, p00_s1};
	assign hi = sq[127:64];

	// Advance partial products, then renormalize
	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1  <= in_x[31:0] * in_x[31:0];
			p01_s1  <= in_x[31:0] * in_x[63:32];
			p11_s1  <= in_x[63:32] * in_x[63:32];
			frac_s1 <= in_frac;
			side_s1 <= in_side;
			side_s2 <= side_s1;
			if (hi[63]) begin
				x_s2    <= hi;
				frac_s2 <= {frac_s1[LOG_STEPS-2:0], 1'b1};
			end else begin
				x_s2    <= {hi[62:0], sq[63]};
				frac_s2 <= {frac_s1[LOG_STEPS-2:0], 1'b0};
			end
		end
	end

	assign out_valid = v_s2;
	assign out_x     = x_s2;
	assign out_frac  = frac_s2;
	assign out_side  = side_s2;

endmodule

`default_nettype wire

FILE: rtl/pgp_root_cell.sv
// One result bit of two square roots, digit by digit; one register stage.
// Depends on pgp_pkg.
`default_nettype none

module pgp_root_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  pgp_pkg::root_side_t          in_side,
	input  logic [63:0]                  in_rad_a,
	input  logic [pgp_pkg::REM_W-1:0]    in_rem_a,
	input  logic [pgp_pkg::ROOT_BITS-1:0] in_root_a,
	input  logic [63:0]                  in_rad_b,
	input  logic [pgp_pkg::REM_W-1:0]    in_rem_b,
	input  logic [pgp_pkg::ROOT_BITS-1:0] in_root_b,
	output logic                         out_valid,
	output pgp_pkg::root_side_t          out_side,
	output logic [63:0]                  out_rad_a,
	output logic [pgp_pkg::REM_W-1:0]    out_rem_a,
	output logic [pgp_pkg::ROOT_BITS-1:0] out_root_a,
	output logic [63:0]                  out_rad_b,
	output logic [pgp_pkg::REM_W-1:0]    out_rem_b,
	output logic [pgp_pkg::ROOT_BITS-1:0] out_root_b
);
	import pgp_pkg::*;

	localparam int LANE_W = 64 + REM_W + ROOT_BITS;

	logic              v_s1;
	root_side_t        side_s1;
	logic [LANE_W-1:0] lane_a_s1, lane_b_s1;

	// Shift in two radicand bits and try the next root bit
	function automatic logic [LANE_W-1:0] root_step(input logic [63:0] rad,
			input logic [REM_W-1:0] rem, input logic [ROOT_BITS-1:0] root);
		logic [REM_W+1:0] rem2;
		logic [REM_W+1:0] trial;
		logic [REM_W+1:0] diff;
		rem2  = {rem, rad[63:62]};
		trial = {2'b00, root, 2'b01};
		diff  = rem2 - trial;
		if (rem2 >= trial) begin
			return {rad[61:0], 2'b00, diff[REM_W-1:0], root[ROOT_BITS-2:0], 1'b1};
		end
		return {rad[61:0], 2'b00, rem2[REM_W-1:0], root[ROOT_BITS-2:0], 1'b0};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1   <= in_side;
			lane_a_s1 <= root_step(in_rad_a, in_rem_a, in_root_a);
			lane_b_s1 <= root_step(in_rad_b, in_rem_b, in_root_b);
		end
	end

	assign out_valid = v_s1;
	assign out_side  = side_s1;
	assign {out_rad_a, out_rem_a, out_root_a} = lane_a_s1;
	assign {out_rad_b, out_rem_b, out_root_b} = lane_b_s1;

endmodule

`default_nettype wire

FILE: rtl/pgp_div_cell.sv
// One quotient bit of two restoring divisions by a shared divisor; one register stage.
// Depends on pgp_pkg.
`default_nettype none

module pgp_div_cell #(
	parameter int DW = 34
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [1:0]                  in_neg,
	input  logic [DW-1:0]               in_den,
	input  logic [31:0]                 in_num_a,
	input  logic [DW-1:0]               in_rem_a,
	input  logic [pgp_pkg::QUO_BITS-1:0] in_quo_a,
	input  logic                        in_sat_a,
	input  logic [31:0]                 in_num_b,
	input  logic [DW-1:0]               in_rem_b,
	input  logic [pgp_pkg::QUO_BITS-1:0] in_quo_b,
	input  logic                        in_sat_b,
	output logic                        out_valid,
	output logic [1:0]                  out_neg,
	output logic [DW-1:0]               out_den,
	output logic [31:0]                 out_num_a,
	output logic [DW-1:0]               out_rem_a,
	output logic [pgp_pkg::QUO_BITS-1:0] out_quo_a,
	output logic                        out_sat_a,
	output logic [31:0]                 out_num_b,
	output logic [DW-1:0]               out_rem_b,
	output logic [pgp_pkg::QUO_BITS-1:0] out_quo_b,
	output logic                        out_sat_b
);
	import pgp_pkg::*;

	localparam int LANE_W = 32 + DW + QUO_BITS;

	logic              v_s1;
	logic [1:0]        neg_s1;
	logic [DW-1:0]     den_s1;
	logic              sat_a_s1, sat_b_s1;
	logic [LANE_W-1:0] lane_a_s1, lane_b_s1;

	// Bring down one numerator bit and subtract where it fits
	function automatic logic [LANE_W-1:0] div_step(input logic [31:0] num,
			input logic [DW-1:0] rem, input logic [QUO_BITS-1:0] quo,
			input logic [DW-1:0] den);
		logic [DW:0] remx;
		logic [DW:0] diff;
		remx = {rem, num[31]};
		diff = remx - {1'b0, den};
		if (remx >= {1'b0, den}) begin
			return {num[30:0], 1'b0, diff[DW-1:0], quo[QUO_BITS-2:0], 1'b1};
		end
		return {num[30:0], 1'b0, remx[DW-1:0], quo[QUO_BITS-2:0], 1'b0};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1    <= in_neg;
			den_s1    <= in_den;
			sat_a_s1  <= in_sat_a;
			sat_b_s1  <= in_sat_b;
			lane_a_s1 <= div_step(in_num_a, in_rem_a, in_quo_a, in_den);
			lane_b_s1 <= div_step(in_num_b, in_rem_b, in_quo_b, in_den);
		end
	end

	assign out_valid = v_s1;
	assign out_neg   = neg_s1;
	assign out_den   = den_s1;
	assign out_sat_a = sat_a_s1;
	assign out_sat_b = sat_b_s1;
	assign {out_num_a, out_rem_a, out_quo_a} = lane_a_s1;
	assign {out_num_b, out_rem_b, out_quo_b} = lane_b_s1;

endmodule

`default_nettype wire

FILE: rtl/polar_gaussian_pair_unit.sv
// The first deviate of a kept pair shows on m_tdata, the second once the first has
// been taken; rejected pairs give nothing. The chain takes a new pair before older ones leave it.
// Throughput: the one-deviate-per-cycle output register (while m_tready is high)
// stalls the cell chain until the second deviate of a kept pair is taken.
// Reset: arst_n clears all valid bits and the output valid and phase flags at once.
`default_nettype none

module polar_gaussian_pair_unit #(
	parameter int UNIFORM_BITS  = pgp_pkg::UNIFORM_BITS_DEF,
	parameter int OUT_FRAC_BITS = pgp_pkg::OUT_FRAC_BITS_DEF,
	localparam int IN_W = ((2 * UNIFORM_BITS + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [IN_W-1:0] s_tdata,  // first_uniform, second_uniform, zero fill
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [31:0]     m_tdata,  // gaussian_sample
	output logic            m_tlast   // is_last
);
	import pgp_pkg::*;

	localparam int EXT = (OUT_FRAC_BITS > 28) ? OUT_FRAC_BITS - 28 : 0;
	localparam int SH  = (OUT_FRAC_BITS < 28) ? 28 - OUT_FRAC_BITS : 0;
	localparam int NW  = 64 + EXT;
	localparam int DW  = 32 + SH;
	localparam int HW  = NW - 32;
	localparam int MW  = (HW > DW) ? HW : DW;

	logic en;

	// ---------------- front end ----------------
	logic [31:0] o1, o2, a1_c, a2_c;

	if (UNIFORM_BITS >= 32) begin : g_wide
		assign o1 = s_tdata[UNIFORM_BITS-1 -: 32];
		assign o2 = s_tdata[2*UNIFORM_BITS-1 -: 32];
	end else begin : g_narrow
		assign o1 = {s_tdata[UNIFORM_BITS-1:0], {(32-UNIFORM_BITS){1'b0}}};
		assign o2 = {s_tdata[2*UNIFORM_BITS-1:UNIFORM_BITS], {(32-UNIFORM_BITS){1'b0}}};
	end

	assign a1_c = o1[31] ? {1'b0, o1[30:0]} : HALF_RANGE - o1;
	assign a2_c = o2[31] ? {1'b0, o2[30:0]} : HALF_RANGE - o2;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [31:0] a1_s1, a2_s1, a1_s2, a2_s2, a1_s3, a2_s3;
	logic        n1_s1, n2_s1, n1_s2, n2_s2, n1_s3, n2_s3;
	logic [63:0] sq1_s2, sq2_s2, r_s3, x_s4;
	logic [63:0] r_sum;
	logic        r_keep;
	log_side_t   side_s4;

	assign r_sum  = sq1_s2 + sq2_s2;
	assign r_keep = (r_sum != 64'd0) && (r_sum <= CIRCLE_LIMIT);

	// Normalization of r and the components
	logic [5:0]  p_c;
	logic [4:0]  k_c;
	logic [63:0] vn1_c, vn2_c;
	assign p_c   = msb_index(r_s3);
	assign k_c   = 5'((6'd62 - p_c) >> 1);
	assign vn1_c = {32'd0, a1_s3} << k_c;
	assign vn2_c = {32'd0, a2_s3} << k_c;

	// ---------------- log chain wiring ----------------
	logic                 lv   [0:LOG_STEPS];
	logic [63:0]          lx   [0:LOG_STEPS];
	logic [LOG_STEPS-1:0] lf   [0:LOG_STEPS];
	log_side_t            ls   [0:LOG_STEPS];

	assign lv[0] = v_s4;
	assign lx[0] = x_s4;
	assign lf[0] = '0;
	assign ls[0] = side_s4;

	for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
		pgp_log_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (lv[i]),
			.in_x     (lx[i]),
			.in_frac  (lf[i]),
			.in_side  (ls[i]),
			.out_valid(lv[i+1]),
			.out_x    (lx[i+1]),
			.out_frac (lf[i+1]),
			.out_side (ls[i+1])
		);
	end

	// ---------------- -2 ln r ----------------
	logic        v_s5, v_s6, v_s7;
	logic [63:0] lval_s5, rp_s5, rp_s6, rp_s7, t_s7;
	root_side_t  rs_s5, rs_s6, rs_s7;
	logic [63:0] pr00_s6, pr01_s6, pr10_s6, pr11_s6;
	logic [127:0] lc_sum;

	assign lc_sum = {pr11_s6, 64'd0} + {32'd0, pr01_s6, 32'd0}
	              + {32'd0, pr10_s6, 32'd0} + {64'd0, pr00_s6};

	// ---------------- root chain wiring ----------------
	logic                 qv  [0:ROOT_BITS];
	root_side_t           qs  [0:ROOT_BITS];
	logic [63:0]          qra [0:ROOT_BITS];
	logic [REM_W-1:0]     qma [0:ROOT_BITS];
	logic [ROOT_BITS-1:0] qta [0:ROOT_BITS];
	logic [63:0]          qrb [0:ROOT_BITS];
	logic [REM_W-1:0]     qmb [0:ROOT_BITS];
	logic [ROOT_BITS-1:0] qtb [0:ROOT_BITS];

	assign qv[0]  = v_s7;
	assign qs[0]  = rs_s7;
	assign qra[0] = t_s7;
	assign qma[0] = '0;
	assign qta[0] = '0;
	assign qrb[0] = rp_s7;
	assign qmb[0] = '0;
	assign qtb[0] = '0;

	for (genvar i = 0; i < ROOT_BITS; i++) begin : g_root
		pgp_root_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (qv[i]),
			.in_side   (qs[i]),
			.in_rad_a  (qra[i]),
			.in_rem_a  (qma[i]),
			.in_root_a (qta[i]),
			.in_rad_b  (qrb[i]),
			.in_rem_b  (qmb[i]),
			.in_root_b (qtb[i]),
			.out_valid (qv[i+1]),
			.out_side  (qs[i+1]),
			.out_rad_a (qra[i+1]),
			.out_rem_a (qma[i+1]),
			.out_root_a(qta[i+1]),
			.out_rad_b (qrb[i+1]),
			.out_rem_b (qmb[i+1]),
			.out_root_b(qtb[i+1])
		);
	end

	// ---------------- numerators and divisor ----------------
	logic          v_s8, v_s9;
	logic [1:0]    neg_s8, neg_s9;
	logic [NW-1:0] num1_s8, num2_s8;
	logic [DW-1:0] den_s8, den_s9;
	logic [63:0]   prod1, prod2;
	logic [31:0]   nl1_s9, nl2_s9;
	logic [DW-1:0] rem1_s9, rem2_s9;
	logic          sat1_s9, sat2_s9;
	logic [HW-1:0] hi1, hi2;

	assign prod1 = qs[ROOT_BITS].vn1 * qta[ROOT_BITS];
	assign prod2 = qs[ROOT_BITS].vn2 * qta[ROOT_BITS];
	assign hi1   = num1_s8[NW-1:32];
	assign hi2   = num2_s8[NW-1:32];

	// ---------------- divider chain wiring ----------------
	logic                dv  [0:QUO_BITS];
	logic [1:0]          dn  [0:QUO_BITS];
	logic [DW-1:0]       dd  [0:QUO_BITS];
	logic [31:0]         dna [0:QUO_BITS];
	logic [DW-1:0]       dra [0:QUO_BITS];
	logic [QUO_BITS-1:0] dqa [0:QUO_BITS];
	logic                dsa [0:QUO_BITS];
	logic [31:0]         dnb [0:QUO_BITS];
	logic [DW-1:0]       drb [0:QUO_BITS];
	logic [QUO_BITS-1:0] dqb [0:QUO_BITS];
	logic                dsb [0:QUO_BITS];

	assign dv[0]  = v_s9;
	assign dn[0]  = neg_s9;
	assign dd[0]  = den_s9;
	assign dna[0] = nl1_s9;
	assign dra[0] = rem1_s9;
	assign dqa[0] = '0;
	assign dsa[0] = sat1_s9;
	assign dnb[0] = nl2_s9;
	assign drb[0] = rem2_s9;
	assign dqb[0] = '0;
	assign dsb[0] = sat2_s9;

	for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
		pgp_div_cell #(.DW(DW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (dv[i]),
			.in_neg   (dn[i]),
			.in_den   (dd[i]),
			.in_num_a (dna[i]),
			.in_rem_a (dra[i]),
			.in_quo_a (dqa[i]),
			.in_sat_a (dsa[i]),
			.in_num_b (dnb[i]),
			.in_rem_b (drb[i]),
			.in_quo_b (dqb[i]),
			.in_sat_b (dsb[i]),
			.out_valid(dv[i+1]),
			.out_neg  (dn[i+1]),
			.out_den  (dd[i+1]),
			.out_num_a(dna[i+1]),
			.out_rem_a(dra[i+1]),
			.out_quo_a(dqa[i+1]),
			.out_sat_a(dsa[i+1]),
			.out_num_b(dnb[i+1]),
			.out_rem_b(drb[i+1]),
			.out_quo_b(dqb[i+1]),
			.out_sat_b(dsb[i+1])
		);
	end

	// Apply sign and saturate
	function automatic logic [31:0] clip_out(input logic neg, input logic sat,
			input logic [QUO_BITS-1:0] quo);
		logic [31:0] mag;
		mag = sat ? '1 : 32'(quo);
		if (neg) begin
			if (mag > HALF_RANGE) mag = HALF_RANGE;
			return 32'd0 - mag;
		end
		if (mag > HALF_RANGE - 32'd1) mag = HALF_RANGE - 32'd1;
		return mag;
	endfunction

	// ---------------- output register ----------------
	logic        hold_v_q, phase_q;
	logic [31:0] dev1_q, dev2_q;

	assign en       = !hold_v_q || (phase_q && m_tready);
	assign s_tready = en;
	assign m_tvalid = hold_v_q;
	assign m_tdata  = phase_q ? dev2_q : dev1_q;
	assign m_tlast  = phase_q;

	// Advance valid bits of the plain stages and hold the output state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			v_s8     <= 1'b0;
			v_s9     <= 1'b0;
			hold_v_q <= 1'b0;
			phase_q  <= 1'b0;
		end else if (en) begin
			v_s1     <= s_tvalid;
			v_s2     <= v_s1;
			v_s3     <= v_s2 && r_keep;
			v_s4     <= v_s3;
			v_s5     <= lv[LOG_STEPS];
			v_s6     <= v_s5;
			v_s7     <= v_s6;
			v_s8     <= qv[ROOT_BITS];
			v_s9     <= v_s8;
			hold_v_q <= dv[QUO_BITS];
			phase_q  <= 1'b0;
		end else if (m_tready) begin
			phase_q  <= 1'b1;
		end
	end

	// Advance the payload of the plain stages
	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1  <= a1_c;
			a2_s1  <= a2_c;
			n1_s1  <= !o1[31];
			n2_s1  <= !o2[31];
			sq1_s2 <= a1_s1 * a1_s1;
			sq2_s2 <= a2_s1 * a2_s1;
			a1_s2  <= a1_s1;
			a2_s2  <= a2_s1;
			n1_s2  <= n1_s1;
			n2_s2  <= n2_s1;
			r_s3   <= r_sum;
			a1_s3  <= a1_s2;
			a2_s3  <= a2_s2;
			n1_s3  <= n1_s2;
			n2_s3  <= n2_s2;
			x_s4   <= r_s3 << (6'd63 - p_c);
			side_s4.msb      <= p_c;
			side_s4.rad_norm <= r_s3 << {k_c, 1'b0};
			side_s4.vn1      <= vn1_c[31:0];
			side_s4.vn2      <= vn2_c[31:0];
			side_s4.neg1     <= n1_s3;
			side_s4.neg2     <= n2_s3;

			lval_s5 <= {2'b00, 6'd62 - ls[LOG_STEPS].msb, 56'd0}
			         - {8'd0, lf[LOG_STEPS]};
			rp_s5    <= ls[LOG_STEPS].rad_norm;
			rs_s5.vn1  <= ls[LOG_STEPS].vn1;
			rs_s5.vn2  <= ls[LOG_STEPS].vn2;
			rs_s5.neg1 <= ls[LOG_STEPS].neg1;
			rs_s5.neg2 <= ls[LOG_STEPS].neg2;
			pr00_s6 <= lval_s5[31:0]  * LN2X2_Q62[31:0];
			pr01_s6 <= lval_s5[31:0]  * LN2X2_Q62[63:32];
			pr10_s6 <= lval_s5[63:32] * LN2X2_Q62[31:0];
			pr11_s6 <= lval_s5[63:32] * LN2X2_Q62[63:32];
			rp_s6   <= rp_s5;
			rs_s6   <= rs_s5;
			t_s7    <= lc_sum[125:62];
			rp_s7   <= rp_s6;
			rs_s7   <= rs_s6;

			num1_s8 <= NW'(prod1) << EXT;
			num2_s8 <= NW'(prod2) << EXT;
			den_s8  <= DW'(qtb[ROOT_BITS]) << SH;
			neg_s8  <= {qs[ROOT_BITS].neg2, qs[ROOT_BITS].neg1};
			sat1_s9 <= MW'(hi1) >= MW'(den_s8);
			sat2_s9 <= MW'(hi2) >= MW'(den_s8);
			rem1_s9 <= DW'(hi1);
			rem2_s9 <= DW'(hi2);
			nl1_s9  <= num1_s8[31:0];
			nl2_s9  <= num2_s8[31:0];
			den_s9  <= den_s8;
			neg_s9  <= neg_s8;

			dev1_q <= clip_out(dn[QUO_BITS][0], dsa[QUO_BITS], dqa[QUO_BITS]);
			dev2_q <= clip_out(dn[QUO_BITS][1], dsb[QUO_BITS], dqb[QUO_BITS]);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pgp_checker.sv
// Port-level checks for the polar Gaussian pair unit, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pgp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	// A stalled deviate stays offered
	`PGP_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> m_tvalid, "output valid dropped")

	// A stalled deviate keeps its value
	`PGP_ASSERT(a_out_stable, (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)), "output changed while stalled")

	// The first deviate is followed by the second of the same pair
	`PGP_ASSERT(a_pair_order, (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast), "second deviate missing")

	// No new input while the first deviate waits
	`PGP_ASSERT(a_in_block, (m_tvalid && !m_tlast) |-> !s_tready, "input taken with a deviate pending")

	// Nothing offered during reset
	`PGP_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_tvalid, "output valid during reset")

endmodule

bind polar_gaussian_pair_unit pgp_checker u_pgp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

`default_nettype wire
